// ===== src/mct_pkg.sv =====
// Shared types and constants for the MIDI channel state tracker.
`timescale 1ns / 1ps

package mct_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int KEY_W            = 7;
    localparam int PITCH_W          = 14;

    localparam logic [7:0] CMD_NOTE_ON = 8'h90;
    localparam logic [7:0] CMD_CONTROL = 8'hB0;
    localparam logic [7:0] CMD_PITCH   = 8'hE0;
    localparam logic [7:0] CMD_MASK    = 8'hF0;
    localparam logic [7:0] CHAN_MASK   = 8'h0F;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic exec;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== src/midi_channel_state_tracker.sv =====
// Top level of the MIDI channel state tracker.
//
// Input channel (s_): one beat is either a MIDI short message (s_req_type 0)
// with running status, or a state query (s_req_type 1) on note velocity,
// controller value or pitch bend of one channel and key.
// Result channel (m_): one beat per input beat, in order: the decoded event
// for a message, or the stored value in m_state_value for a query.
// Each beat is captured, then executed (table write or read), then its
// result is loaded; the sequencer takes no new beat until that load, since
// the table read is registered.
// The result sits in an output register, so the next beat is taken while a
// result waits; a stalled receiver holds the block in its load step once the
// following beat has been taken.
// Reset: synchronous, active low. Running status and pitch bend values clear
// at once; the note and controller tables are then swept to zero, one entry
// a cycle over all 128 * NUM_CHANNELS entries, with s_ready low throughout.
`timescale 1ns / 1ps

module midi_channel_state_tracker
    import mct_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [7:0]         s_msg_first,
    input  logic [7:0]         s_msg_second,
    input  logic [7:0]         s_msg_third,
    input  logic [7:0]         s_query_command,
    input  logic [3:0]         s_query_channel,
    input  logic [KEY_W-1:0]   s_query_key,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_event_command,
    output logic [3:0]         m_event_channel,
    output logic [KEY_W-1:0]   m_event_data_first,
    output logic [KEY_W-1:0]   m_event_data_second,
    output logic [PITCH_W-1:0] m_state_value
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    mct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mct_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .s_req_type          (s_req_type),
        .s_msg_first         (s_msg_first),
        .s_msg_second        (s_msg_second),
        .s_msg_third         (s_msg_third),
        .s_query_command     (s_query_command),
        .s_query_channel     (s_query_channel),
        .s_query_key         (s_query_key),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_event_command     (m_event_command),
        .m_event_channel     (m_event_channel),
        .m_event_data_first  (m_event_data_first),
        .m_event_data_second (m_event_data_second),
        .m_state_value       (m_state_value)
    );

    // one beat in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    // tables are swept after reset before anything is taken
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken during table clear");

    // events and query answers never mix
    a_event_or_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_command != 8'h00 |-> m_state_value == '0)
        else $error("event carries a state value");

    // a new result follows its input beat through the execute and load steps
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 3) || $past(!m_valid || m_ready))
        else $error("result without input");

endmodule

// ===== src/mct_ctrl.sv =====
// Sequencing state machine: table clear, beat capture, execute, result load.
`timescale 1ns / 1ps

module mct_ctrl
    import mct_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== src/mct_datapath.sv =====
// Decode, running status, channel tables and result register.
`timescale 1ns / 1ps

module mct_datapath
    import mct_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctrl_cmd_t          cmd,
    output ctrl_sts_t          sts,
    input  logic               s_req_type,
    input  logic [7:0]         s_msg_first,
    input  logic [7:0]         s_msg_second,
    input  logic [7:0]         s_msg_third,
    input  logic [7:0]         s_query_command,
    input  logic [3:0]         s_query_channel,
    input  logic [KEY_W-1:0]   s_query_key,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_event_command,
    output logic [3:0]         m_event_channel,
    output logic [KEY_W-1:0]   m_event_data_first,
    output logic [KEY_W-1:0]   m_event_data_second,
    output logic [PITCH_W-1:0] m_state_value
);

    localparam int DEPTH  = NUM_CHANNELS * (2 ** KEY_W);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [4:0]        NCH       = 5'(NUM_CHANNELS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // captured beat
    logic               req_reg;
    logic [7:0]         first_reg, second_reg, third_reg, qcmd_reg;
    logic [3:0]         qchan_reg;
    logic [KEY_W-1:0]   qkey_reg;

    // running status
    logic [7:0]         run_cmd_reg;
    logic [3:0]         run_chan_reg;

    // decoded event
    logic [7:0]         ev_cmd_reg;
    logic [3:0]         ev_chan_reg;
    logic [KEY_W-1:0]   ev_d0_reg, ev_d1_reg;

    // query read side
    logic               q_note_reg, q_ctrl_reg, q_pitch_reg;
    logic [KEY_W-1:0]   note_rd_reg, ctrl_rd_reg;
    logic [PITCH_W-1:0] pitch_rd_reg;

    logic [ADDR_W-1:0]  clr_addr_reg;

    logic [KEY_W-1:0]   note_mem [0:DEPTH-1];
    logic [KEY_W-1:0]   ctrl_mem [0:DEPTH-1];
    logic [PITCH_W-1:0] pitch_reg [0:NUM_CHANNELS-1];

    logic               m_valid_reg;
    logic [7:0]         m_cmd_reg;
    logic [3:0]         m_chan_reg;
    logic [KEY_W-1:0]   m_d0_reg, m_d1_reg;
    logic [PITCH_W-1:0] m_value_reg;

    // message decode
    logic               has_status;
    logic [7:0]         dec_cmd;
    logic [3:0]         dec_chan;
    logic [KEY_W-1:0]   dec_d0, dec_d1;
    logic               dec_chan_ok;
    logic [CH_W-1:0]    dec_idx;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_note, wr_ctrl, wr_pitch;
    logic [KEY_W-1:0]   wr_data;

    // query decode
    logic               q_chan_ok;
    logic [CH_W-1:0]    q_idx;
    logic [ADDR_W-1:0]  rd_addr;
    logic               is_msg_exec, is_query_exec;

    assign has_status = first_reg[7];
    assign dec_cmd    = has_status ? (first_reg & CMD_MASK) : run_cmd_reg;
    assign dec_chan   = has_status ? 4'(first_reg & CHAN_MASK) : run_chan_reg;
    assign dec_d0     = has_status ? second_reg[KEY_W-1:0] : first_reg[KEY_W-1:0];
    assign dec_d1     = has_status ? third_reg[KEY_W-1:0] : second_reg[KEY_W-1:0];

    assign dec_chan_ok = {1'b0, dec_chan} < NCH;
    assign dec_idx     = dec_chan_ok ? dec_chan[CH_W-1:0] : '0;
    assign q_chan_ok   = {1'b0, qchan_reg} < NCH;
    assign q_idx       = q_chan_ok ? qchan_reg[CH_W-1:0] : '0;

    assign is_msg_exec   = cmd.exec && !req_reg;
    assign is_query_exec = cmd.exec && req_reg;

    assign wr_note  = cmd.clear || (is_msg_exec && dec_chan_ok && dec_cmd == CMD_NOTE_ON);
    assign wr_ctrl  = cmd.clear || (is_msg_exec && dec_chan_ok && dec_cmd == CMD_CONTROL);
    assign wr_pitch = is_msg_exec && dec_chan_ok && dec_cmd == CMD_PITCH;
    assign wr_addr  = cmd.clear ? clr_addr_reg : ADDR_W'({dec_idx, dec_d0});
    assign wr_data  = cmd.clear ? '0 : dec_d1;
    assign rd_addr  = ADDR_W'({q_idx, qkey_reg});

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg    <= s_req_type;
            first_reg  <= s_msg_first;
            second_reg <= s_msg_second;
            third_reg  <= s_msg_third;
            qcmd_reg   <= s_query_command;
            qchan_reg  <= s_query_channel;
            qkey_reg   <= s_query_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_cmd_reg  <= '0;
            run_chan_reg <= '0;
        end else if (is_msg_exec && has_status) begin
            run_cmd_reg  <= dec_cmd;
            run_chan_reg <= dec_chan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear && clr_addr_reg != LAST_ADDR) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign sts.clear_done = cmd.clear && clr_addr_reg == LAST_ADDR;
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (wr_note) begin
            note_mem[wr_addr] <= wr_data;
        end
        if (is_query_exec) begin
            note_rd_reg <= note_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ctrl) begin
            ctrl_mem[wr_addr] <= wr_data;
        end
        if (is_query_exec) begin
            ctrl_rd_reg <= ctrl_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                pitch_reg[i] <= '0;
            end
        end else if (wr_pitch) begin
            pitch_reg[dec_idx] <= {dec_d1, dec_d0};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            ev_cmd_reg   <= dec_cmd;
            ev_chan_reg  <= dec_chan;
            ev_d0_reg    <= dec_d0;
            ev_d1_reg    <= dec_d1;
            q_note_reg   <= q_chan_ok && qcmd_reg == CMD_NOTE_ON;
            q_ctrl_reg   <= q_chan_ok && qcmd_reg == CMD_CONTROL;
            q_pitch_reg  <= q_chan_ok && qcmd_reg == CMD_PITCH;
            pitch_rd_reg <= pitch_reg[q_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (req_reg) begin
                m_cmd_reg  <= '0;
                m_chan_reg <= '0;
                m_d0_reg   <= '0;
                m_d1_reg   <= '0;
                if (q_note_reg) begin
                    m_value_reg <= PITCH_W'(note_rd_reg);
                end else if (q_ctrl_reg) begin
                    m_value_reg <= PITCH_W'(ctrl_rd_reg);
                end else if (q_pitch_reg) begin
                    m_value_reg <= pitch_rd_reg;
                end else begin
                    m_value_reg <= '0;
                end
            end else begin
                m_cmd_reg   <= ev_cmd_reg;
                m_chan_reg  <= ev_chan_reg;
                m_d0_reg    <= ev_d0_reg;
                m_d1_reg    <= ev_d1_reg;
                m_value_reg <= '0;
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_event_command     = m_cmd_reg;
    assign m_event_channel     = m_chan_reg;
    assign m_event_data_first  = m_d0_reg;
    assign m_event_data_second = m_d1_reg;
    assign m_state_value       = m_value_reg;

endmodule
